// File: src/vesl_pkg.sv
// Shared types and constants for the velocity estimator with spring lock.
// Holds the controller-to-datapath command struct, field layout, filter
// coefficients and the saturation helper. No dependencies.
`default_nettype none

package vesl_pkg;

  // Field layout of the stream payloads
  localparam int DATA_W   = 32;
  localparam int MAX_AXES = 3;
  localparam int AXES_DEF = 3;
  localparam int BTN_W    = 2;
  localparam int BTN_LSB  = 2 * MAX_AXES * DATA_W;
  localparam int IN_W     = ((BTN_LSB + BTN_W + 7) / 8) * 8;
  localparam int OUT_W    = ((BTN_LSB + BTN_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOCK_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_POS_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2621;

  // Datapath widths: 3p - 4p1 + p2 needs 35 bits, coefficients fit 32
  localparam int OPA_W  = 35;
  localparam int OPB_W  = 32;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int DIFF_W = DATA_W + 1;

  localparam int COEF_BITS = 28;
  localparam int GAIN_BITS = 16;

  localparam logic signed [OPB_W-1:0] INV_DT = 32'sd500;
  localparam logic signed [OPB_W-1:0] CB0    = 32'sd58948;
  localparam logic signed [OPB_W-1:0] CB1    = 32'sd176845;
  // Feedback coefficients stored negated so every term is added
  localparam logic signed [OPB_W-1:0] NA1    = 32'sd737875381;
  localparam logic signed [OPB_W-1:0] NA2    = -32'sd678658520;
  localparam logic signed [OPB_W-1:0] NA3    = 32'sd208735411;

  typedef enum logic [2:0] {
    MS_VEL,
    MS_SPRING,
    MS_B0,
    MS_B1,
    MS_A1,
    MS_A2,
    MS_A3
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     diff_en;
    logic     satx_en;
    logic     force_en;
    logic     acc_load;
    logic     acc_add;
    logic     commit;
    logic     out_load;
    mul_sel_e sel;
  } cmd_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-DATA_W:0] hi;
    hi = v[PROD_W-1:DATA_W-1];
    if (hi == '0 || hi == '1) begin
      return v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// File: src/vesl_ctrl.sv
// Sequencer for the velocity estimator: walks each axis through a fixed
// schedule of steps and drives the stream handshakes. Uses vesl_pkg.
`default_nettype none

module vesl_ctrl #(
  parameter int  AXES   = vesl_pkg::AXES_DEF,
  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              m_ready_i,
  output logic              m_valid_o,
  output vesl_pkg::cmd_t    cmd_o,
  output logic [AXIS_W-1:0] axis_o
);
  import vesl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Steps of one axis; a product is usable once its operands have passed the operand and product registers
  localparam logic [3:0] SP_DIFF    = 4'd0;
  localparam logic [3:0] SP_VEL     = 4'd1;
  localparam logic [3:0] SP_MUL_VEL = 4'd2;
  localparam logic [3:0] SP_SATX    = 4'd3;
  localparam logic [3:0] SP_B0      = 4'd4;
  localparam logic [3:0] SP_FORCE   = 4'd5;
  localparam logic [3:0] SP_ACC0    = 4'd6;
  localparam logic [3:0] SP_ACC1    = 4'd7;
  localparam logic [3:0] SP_ACC2    = 4'd8;
  localparam logic [3:0] SP_ACC3    = 4'd9;
  localparam logic [3:0] SP_ACC4    = 4'd10;
  localparam logic [3:0] SP_COMMIT  = 4'd11;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  logic [1:0]        state_q, state_d;
  logic [3:0]        step_q, step_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic              m_valid_q, m_valid_d;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    axis_d    = axis_q;
    cmd_o     = '0;
    cmd_o.sel = MS_VEL;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          step_d     = SP_DIFF;
          axis_d     = '0;
        end
      end
      ST_RUN: begin
        step_d = 4'(step_q + 4'd1);
        case (step_q)
          SP_DIFF:    cmd_o.diff_en = 1'b1;
          SP_VEL:     cmd_o.sel = MS_VEL;
          SP_MUL_VEL: cmd_o.sel = MS_VEL;
          SP_SATX: begin
            cmd_o.satx_en = 1'b1;
            cmd_o.sel     = MS_SPRING;
          end
          SP_B0:      cmd_o.sel = MS_B0;
          SP_FORCE: begin
            cmd_o.force_en = 1'b1;
            cmd_o.sel      = MS_B1;
          end
          SP_ACC0: begin
            cmd_o.acc_load = 1'b1;
            cmd_o.sel      = MS_A1;
          end
          SP_ACC1: begin
            cmd_o.acc_add = 1'b1;
            cmd_o.sel     = MS_A2;
          end
          SP_ACC2: begin
            cmd_o.acc_add = 1'b1;
            cmd_o.sel     = MS_A3;
          end
          SP_ACC3, SP_ACC4: cmd_o.acc_add = 1'b1;
          SP_COMMIT: begin
            cmd_o.commit = 1'b1;
            step_d       = SP_DIFF;
            if (axis_q == LAST_AXIS) begin
              state_d = ST_DONE;
            end else begin
              axis_d = AXIS_W'(axis_q + 1'b1);
            end
          end
          default: begin
            step_d  = SP_DIFF;
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= SP_DIFF;
      axis_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      axis_q    <= axis_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign axis_o    = axis_q;

endmodule

`default_nettype wire

// File: src/vesl_dp.sv
// Datapath of the velocity estimator: input and config registers, per-axis
// histories, one shared multiplier with accumulator, and the result register.
// Driven by vesl_ctrl through vesl_pkg::cmd_t.
`default_nettype none

module vesl_dp #(
  parameter int  AXES   = vesl_pkg::AXES_DEF,
  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vesl_pkg::cmd_t                    cmd_i,
  input  logic [AXIS_W-1:0]                 axis_i,
  input  logic [vesl_pkg::IN_W-1:0]         in_data_i,
  input  logic                              cfg_we_i,
  input  logic [vesl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vesl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic [vesl_pkg::OUT_W-1:0]        out_data_o
);
  import vesl_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF_COEF = PROD_W'(1) <<< (COEF_BITS - 1);
  localparam logic signed [PROD_W-1:0] HALF_GAIN = PROD_W'(1) <<< (GAIN_BITS - 1);

  // Configuration
  logic                     lock_en_q;
  logic signed [DATA_W-1:0] lock_pos_q [AXES];
  logic [GAIN_W-1:0]        gain_q;

  // Captured request
  logic signed [DATA_W-1:0] pos_q [AXES];
  logic signed [DATA_W-1:0] cmdf_q [AXES];
  logic [BTN_W-1:0]         btn_q;

  // Histories per axis
  logic signed [DATA_W-1:0] p1_q [AXES];
  logic signed [DATA_W-1:0] p2_q [AXES];
  logic signed [DATA_W-1:0] x1_q [AXES];
  logic signed [DATA_W-1:0] x2_q [AXES];
  logic signed [DATA_W-1:0] x3_q [AXES];
  logic signed [DATA_W-1:0] y1_q [AXES];
  logic signed [DATA_W-1:0] y2_q [AXES];
  logic signed [DATA_W-1:0] y3_q [AXES];

  // Working registers
  logic signed [OPA_W-1:0]  d_q, d_d;
  logic signed [DIFF_W-1:0] sdiff_q, sdiff_d;
  logic signed [DATA_W-1:0] x_q;
  logic signed [OPA_W-1:0]  opa_q, opa_d;
  logic signed [OPB_W-1:0]  opb_q, opb_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] acc_q;
  logic signed [DATA_W-1:0] vel_w_q [AXES];
  logic signed [DATA_W-1:0] force_w_q [AXES];
  logic [OUT_W-1:0]         out_q, out_d;

  logic signed [DATA_W-1:0] p_cur;
  logic signed [PROD_W-1:0] acc_rnd;
  logic signed [PROD_W-1:0] force_rnd;
  logic signed [DATA_W-1:0] y_new;
  logic signed [DATA_W-1:0] force_new;

  assign p_cur     = pos_q[axis_i];
  assign acc_rnd   = (acc_q + HALF_COEF) >>> COEF_BITS;
  assign force_rnd = (prod_q + HALF_GAIN) >>> GAIN_BITS;
  assign y_new     = sat32(acc_rnd);
  assign force_new = lock_en_q ? sat32(force_rnd) : cmdf_q[axis_i];

  assign d_d = (OPA_W'(p_cur) <<< 1) + OPA_W'(p_cur)
             - (OPA_W'(p1_q[axis_i]) <<< 2) + OPA_W'(p2_q[axis_i]);
  assign sdiff_d = DIFF_W'(lock_pos_q[axis_i]) - DIFF_W'(p_cur);

  // Operand select for the shared multiplier
  always_comb begin
    case (cmd_i.sel)
      MS_VEL: begin
        opa_d = d_q;
        opb_d = INV_DT;
      end
      MS_SPRING: begin
        opa_d = OPA_W'(sdiff_q);
        opb_d = OPB_W'({1'b0, gain_q});
      end
      MS_B0: begin
        opa_d = OPA_W'(x_q) + OPA_W'(x3_q[axis_i]);
        opb_d = CB0;
      end
      MS_B1: begin
        opa_d = OPA_W'(x1_q[axis_i]) + OPA_W'(x2_q[axis_i]);
        opb_d = CB1;
      end
      MS_A1: begin
        opa_d = OPA_W'(y1_q[axis_i]);
        opb_d = NA1;
      end
      MS_A2: begin
        opa_d = OPA_W'(y2_q[axis_i]);
        opb_d = NA2;
      end
      MS_A3: begin
        opa_d = OPA_W'(y3_q[axis_i]);
        opb_d = NA3;
      end
      default: begin
        opa_d = '0;
        opb_d = '0;
      end
    endcase
  end

  always_comb begin
    out_d = '0;
    for (int a = 0; a < AXES; a++) begin
      out_d[a*DATA_W +: DATA_W]              = vel_w_q[a];
      out_d[(MAX_AXES+a)*DATA_W +: DATA_W]   = force_w_q[a];
    end
    out_d[BTN_LSB]   = btn_q[0];
    out_d[BTN_LSB+1] = btn_q[1];
  end

  // Configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_en_q <= 1'b0;
      gain_q    <= GAIN_RESET;
      for (int a = 0; a < AXES; a++) begin
        lock_pos_q[a] <= '0;
        p1_q[a]       <= '0;
        p2_q[a]       <= '0;
        x1_q[a]       <= '0;
        x2_q[a]       <= '0;
        x3_q[a]       <= '0;
        y1_q[a]       <= '0;
        y2_q[a]       <= '0;
        y3_q[a]       <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LOCK_EN) begin
          lock_en_q <= cfg_data_i[0];
        end
        if (cfg_idx_i == REG_SPRING_GAIN) begin
          gain_q <= cfg_data_i[GAIN_W-1:0];
        end
        for (int a = 0; a < AXES; a++) begin
          if (cfg_idx_i == CFG_IDX_W'(REG_LOCK_POS_X + a)) begin
            lock_pos_q[a] <= cfg_data_i;
          end
        end
      end
      if (cmd_i.commit) begin
        // advance the delay lines of the current axis
        p2_q[axis_i] <= p1_q[axis_i];
        p1_q[axis_i] <= p_cur;
        x3_q[axis_i] <= x2_q[axis_i];
        x2_q[axis_i] <= x1_q[axis_i];
        x1_q[axis_i] <= x_q;
        y3_q[axis_i] <= y2_q[axis_i];
        y2_q[axis_i] <= y1_q[axis_i];
        y1_q[axis_i] <= y_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int a = 0; a < AXES; a++) begin
        pos_q[a]  <= in_data_i[a*DATA_W +: DATA_W];
        cmdf_q[a] <= in_data_i[(MAX_AXES+a)*DATA_W +: DATA_W];
      end
      btn_q <= in_data_i[BTN_LSB +: BTN_W];
    end
    if (cmd_i.diff_en) begin
      d_q     <= d_d;
      sdiff_q <= sdiff_d;
    end
    if (cmd_i.satx_en) begin
      x_q <= sat32(prod_q);
    end
    if (cmd_i.force_en) begin
      force_w_q[axis_i] <= force_new;
    end
    if (cmd_i.commit) begin
      vel_w_q[axis_i] <= y_new;
    end
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    prod_q <= opa_q * opb_q;
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: src/velocity_estimator_spring_lock.sv
// Velocity estimator with spring lock: backward-difference velocity, 3rd order
// low-pass per axis, spring or commanded force. Uses vesl_ctrl and vesl_dp.
// A request is accepted only in idle, once the previous result has gone into the output
// register; the pace is set by the single shared multiplier that each axis visits for
// seven products in turn, and a stalled result holds off the next request.
// Reset (rst_ni low, async): histories clear to zero, lock off, gain 2621, no output valid.
`default_nettype none

module velocity_estimator_spring_lock #(
  parameter int AXES = vesl_pkg::AXES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y, pos_z, cmd_force_x, cmd_force_y, cmd_force_z, button_bits
  input  logic [vesl_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // vel_x, vel_y, vel_z, force_x, force_y, force_z, button_one, button_two
  output logic [vesl_pkg::OUT_W-1:0]      m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [vesl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vesl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import vesl_pkg::*;

  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;

  cmd_t              cmd;
  logic [AXIS_W-1:0] axis;

  vesl_ctrl #(
    .AXES (AXES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd),
    .axis_o    (axis)
  );

  vesl_dp #(
    .AXES (AXES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .axis_i     (axis),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: tb/tb_velocity_estimator_spring_lock.sv
// Self-checking testbench for velocity_estimator_spring_lock: directed table, then
// random position ramps, holds and noise under changing lock settings, checked by
// an in-bench predictor of the velocity filter and spring force. Needs vesl_pkg.
`timescale 1ns / 100ps

module tb_velocity_estimator_spring_lock;
  import vesl_pkg::*;

  localparam int LATENCY_CYCLES   = 12 * MAX_AXES + 2;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int PHASE_ITEMS      = 100;

  localparam logic [CFG_IDX_W-1:0] REG_LOCK_POS_Y = REG_LOCK_POS_X + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_POS_Z = REG_LOCK_POS_X + 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = REG_SPRING_GAIN + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = '1;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] Q_NEG1 = 32'hffff_ffff;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // Butterworth coefficients in Q.28, differentiator scale 1/0.002 s
  localparam longint FILT_B0  = 64'sd58948;
  localparam longint FILT_B1  = 64'sd176845;
  localparam longint FILT_A1  = -64'sd737875381;
  localparam longint FILT_A2  = 64'sd678658520;
  localparam longint FILT_A3  = -64'sd208735411;
  localparam longint DIFF_SCALE = 64'sd500;
  localparam logic [GAIN_W-1:0] SPRING_K_RESET = 16'd2621;

  typedef struct packed {
    logic [BTN_W-1:0]             buttons;
    logic [2:0][DATA_W-1:0]       cmd_force;
    logic [2:0][DATA_W-1:0]       pos;
  } sample_t;

  typedef struct packed {
    logic                         btn_two;
    logic                         btn_one;
    logic [2:0][DATA_W-1:0]       tool_force;
    logic [2:0][DATA_W-1:0]       vel;
  } servo_out_t;

  typedef struct packed {
    logic                         is_reg;
    logic [CFG_IDX_W-1:0]         reg_idx;
    logic [CFG_DATA_W-1:0]        reg_val;
    sample_t                      smp;
    logic                         typed;
    servo_out_t                   typed_out;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // pos_x, pos_y, pos_z, cmd_force_x, cmd_force_y, cmd_force_z, button_bits
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // vel_x, vel_y, vel_z, force_x, force_y, force_z, button_one, button_two
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  velocity_estimator_spring_lock dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor copy of the block's registers and filter histories (index 0 newest)
  logic                     lock_on = 1'b0;
  logic signed [DATA_W-1:0] lock_target [3] = '{default: '0};
  logic [GAIN_W-1:0]        spring_k = SPRING_K_RESET;
  logic signed [DATA_W-1:0] pos_hist  [3][2] = '{default: '{default: '0}};
  logic signed [DATA_W-1:0] raw_hist  [3][3] = '{default: '{default: '0}};
  logic signed [DATA_W-1:0] filt_hist [3][3] = '{default: '{default: '0}};

  servo_out_t  servo_out_q [$];
  stim_row_t   stim_table [$];
  logic signed [DATA_W-1:0] trail_pos [3] = '{default: '0};

  int unsigned err_count = 0;
  int unsigned stall_cycles = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          sink_hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [DATA_W-1:0] clamp_s32(input longint v);
    if (v > S32_MAX) return Q_MAX;
    if (v < S32_MIN) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Advance the predictor by one servo sample and return the expected output
  function automatic servo_out_t predict_servo(input sample_t smp);
    servo_out_t r;
    longint p, d, acc, diff;
    logic signed [DATA_W-1:0] x, y;
    int a;
    for (a = 0; a < 3; a++) begin
      p = longint'($signed(smp.pos[a]));
      d = 3 * p - 4 * longint'(pos_hist[a][0]) + longint'(pos_hist[a][1]);
      x = clamp_s32(d * DIFF_SCALE);
      acc = FILT_B0 * (longint'(x) + longint'(raw_hist[a][2]))
          + FILT_B1 * (longint'(raw_hist[a][0]) + longint'(raw_hist[a][1]))
          - FILT_A1 * longint'(filt_hist[a][0])
          - FILT_A2 * longint'(filt_hist[a][1])
          - FILT_A3 * longint'(filt_hist[a][2]);
      y = clamp_s32((acc + (64'sd1 <<< 27)) >>> 28);
      pos_hist[a][1]  = pos_hist[a][0];
      pos_hist[a][0]  = smp.pos[a];
      raw_hist[a][2]  = raw_hist[a][1];
      raw_hist[a][1]  = raw_hist[a][0];
      raw_hist[a][0]  = x;
      filt_hist[a][2] = filt_hist[a][1];
      filt_hist[a][1] = filt_hist[a][0];
      filt_hist[a][0] = y;
      r.vel[a] = y;
      if (lock_on) begin
        diff = longint'(lock_target[a]) - p;
        r.tool_force[a] = clamp_s32((diff * longint'(spring_k) + 64'sd32768) >>> 16);
      end else begin
        r.tool_force[a] = smp.cmd_force[a];
      end
    end
    r.btn_one = smp.buttons[0];
    r.btn_two = smp.buttons[1];
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_LOCK_EN:     lock_on = val[0];
      REG_LOCK_POS_X:  lock_target[0] = val;
      REG_LOCK_POS_Y:  lock_target[1] = val;
      REG_LOCK_POS_Z:  lock_target[2] = val;
      REG_SPRING_GAIN: spring_k = val[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic sample_t mk_sample(input logic [DATA_W-1:0] px, py, pz, fx, fy, fz,
                                        input logic [BTN_W-1:0] b);
    sample_t s;
    s.pos[0] = px; s.pos[1] = py; s.pos[2] = pz;
    s.cmd_force[0] = fx; s.cmd_force[1] = fy; s.cmd_force[2] = fz;
    s.buttons = b;
    return s;
  endfunction

  function automatic servo_out_t mk_out(input logic [DATA_W-1:0] vx, vy, vz, fx, fy, fz,
                                        input logic b1, b2);
    servo_out_t o;
    o.vel[0] = vx; o.vel[1] = vy; o.vel[2] = vz;
    o.tool_force[0] = fx; o.tool_force[1] = fy; o.tool_force[2] = fz;
    o.btn_one = b1;
    o.btn_two = b2;
    return o;
  endfunction

  function automatic void add_sample_row(input sample_t smp, input bit typed = 1'b0,
                                         input servo_out_t want = '0);
    stim_row_t row;
    row = '0;
    row.smp = smp;
    row.typed = typed;
    row.typed_out = want;
    stim_table.push_back(row);
  endfunction

  function automatic void add_reg_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    stim_table.push_back(row);
  endfunction

  // Extremes now and then, otherwise a full random word
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_NEG1;
      default: return $urandom();
    endcase
  endfunction

  // Per-sample position step; the upper bands drive the filter into saturation
  function automatic logic [DATA_W-1:0] pick_slope();
    int mag;
    case ($urandom_range(0, 3))
      0: mag = $urandom_range(0, 1023);
      1: mag = $urandom_range(0, 1 << 18);
      2: mag = $urandom_range(4000000, 4294967);
      default: mag = $urandom_range(4294967, 5000000);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic void note_mismatch(input string what, input logic [DATA_W-1:0] got,
                                        input logic [DATA_W-1:0] want);
    err_count++;
    if (err_count <= 10)
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endfunction

  task automatic send_sample(input sample_t smp, input bit typed = 1'b0,
                             input servo_out_t want = '0);
    servo_out_t predicted;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(smp);
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_servo(smp);
    servo_out_q.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold until every result is back and the datapath is quiet
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (servo_out_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] en, px, py, pz, gain);
    settle_block();
    set_reg(REG_LOCK_EN, en);
    set_reg(REG_LOCK_POS_X, px);
    set_reg(REG_LOCK_POS_Y, py);
    set_reg(REG_LOCK_POS_Z, pz);
    set_reg(REG_SPRING_GAIN, gain);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly ramps with random slope, some holds, some pure noise
  task automatic run_phase(input int unsigned n_items, input bit quiet);
    int unsigned sent, seg_len, kind, k;
    int a;
    logic [DATA_W-1:0] slope [3];
    sample_t smp;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      seg_len = (kind <= 5) ? $urandom_range(20, 80) :
                (kind <= 7) ? $urandom_range(5, 30) : $urandom_range(1, 8);
      for (a = 0; a < 3; a++) slope[a] = (kind <= 5) ? pick_slope() : '0;
      src_idle_on = quiet ? 1'b0 : ($urandom_range(0, 2) != 0);
      for (k = 0; k < seg_len && sent < n_items; k++) begin
        for (a = 0; a < 3; a++) begin
          trail_pos[a] = (kind >= 8) ? pick_word() : trail_pos[a] + slope[a];
          smp.pos[a] = trail_pos[a];
          smp.cmd_force[a] = pick_word();
        end
        smp.buttons = BTN_W'($urandom_range(0, 3));
        send_sample(smp);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    bit in_reg;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;

    // Fresh histories: zero positions give zero velocity, commands pass through
    add_sample_row(mk_sample('0, '0, '0, Q_MAX, Q_MIN, '0, 2'b00), 1'b1,
                   mk_out('0, '0, '0, Q_MAX, Q_MIN, '0, 1'b0, 1'b0));
    add_sample_row(mk_sample('0, '0, '0, Q_MIN, Q_MAX, Q_NEG1, 2'b11), 1'b1,
                   mk_out('0, '0, '0, Q_MIN, Q_MAX, Q_NEG1, 1'b1, 1'b1));
    // Full-scale step: raw velocity clamps, first filter tap is b0 times the limit
    add_sample_row(mk_sample(Q_MAX, Q_MIN, '0, 32'd1, Q_NEG1, '0, 2'b01), 1'b1,
                   mk_out(32'd471584, -32'sd471584, '0, 32'd1, Q_NEG1, '0, 1'b1, 1'b0));
    add_sample_row(mk_sample(Q_MIN, Q_MAX, Q_MAX, 32'h0001_0000, '0, Q_MAX, 2'b10));
    add_sample_row(mk_sample(Q_MAX, Q_MAX, Q_MIN, '0, Q_MIN, 32'h1234_5678, 2'b11));
    add_sample_row(mk_sample('0, '0, '0, 32'hdead_beef, 32'h5555_aaaa, 32'haaaa_5555, 2'b00));
    // Writes to unmapped indexes must leave everything alone
    add_reg_row(REG_UNUSED_LO, 32'd1);
    add_reg_row(REG_UNUSED_HI, Q_NEG1);
    add_sample_row(mk_sample(32'h0001_0000, 32'hffff_0000, '0, 32'h1234_5678,
                             32'h8765_4321, Q_NEG1, 2'b01));
    // Strongest spring at opposite ends of the range: force clamps both ways
    add_reg_row(REG_LOCK_EN, 32'd1);
    add_reg_row(REG_LOCK_POS_X, Q_MAX);
    add_reg_row(REG_LOCK_POS_Y, Q_MIN);
    add_reg_row(REG_LOCK_POS_Z, '0);
    add_reg_row(REG_SPRING_GAIN, 32'h0000_ffff);
    add_sample_row(mk_sample(Q_MIN, Q_MAX, '0, Q_MAX, Q_MAX, Q_MAX, 2'b10));
    add_sample_row(mk_sample(Q_MAX, Q_MIN, Q_MIN, '0, '0, '0, 2'b01));
    add_sample_row(mk_sample('0, '0, Q_MAX, '0, '0, '0, 2'b11));
    add_reg_row(REG_SPRING_GAIN, '0);
    add_sample_row(mk_sample(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 2'b00));
    // Only bit 0 of the enable counts
    add_reg_row(REG_LOCK_EN, 32'hffff_fffe);
    add_sample_row(mk_sample('0, '0, '0, 32'h0badc0de, 32'h7654_3210, 32'h0000_0001, 2'b10));
    // Unit gain with rounding right at the half step; upper gain bits are dropped
    add_reg_row(REG_LOCK_EN, 32'd1);
    add_reg_row(REG_LOCK_POS_X, '0);
    add_reg_row(REG_LOCK_POS_Y, '0);
    add_reg_row(REG_SPRING_GAIN, 32'hffff_0001);
    add_sample_row(mk_sample(-32'sd32768, 32'sd32767, -32'sd32769, '0, '0, '0, 2'b01));
    add_sample_row(mk_sample(32'sd32768, -32'sd32767, 32'sd98304, '0, '0, '0, 2'b10));
    add_reg_row(REG_SPRING_GAIN, CFG_DATA_W'(SPRING_K_RESET));
    add_sample_row(mk_sample(32'h0064_0000, 32'hff9c_0000, 32'h0001_8000, '0, '0, '0, 2'b11));
    add_reg_row(REG_LOCK_EN, '0);
    add_sample_row(mk_sample('0, '0, '0, 32'h0002_0000, 32'hfffe_0000, '0, 2'b00));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_reg = 1'b0;
    foreach (stim_table[i]) begin
      if (stim_table[i].is_reg) begin
        if (!in_reg) settle_block();
        in_reg = 1'b1;
        set_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
      end else begin
        if (in_reg) cfg_we_i <= 1'b0;
        in_reg = 1'b0;
        send_sample(stim_table[i].smp, stim_table[i].typed, stim_table[i].typed_out);
      end
    end

    configure('0, $urandom(), $urandom(), $urandom(), CFG_DATA_W'(SPRING_K_RESET));
    run_phase(PHASE_ITEMS, 1'b0);
    configure(32'd1, $urandom(), $urandom(), $urandom(), CFG_DATA_W'(SPRING_K_RESET));
    // Stall the result side long enough for the input to back up
    sink_hold_req = 1'b1;
    run_phase(PHASE_ITEMS, 1'b0);
    configure(32'd1, Q_MAX, Q_MIN, $urandom(), 32'h0000_ffff);
    run_phase(PHASE_ITEMS, 1'b0);
    configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_phase(PHASE_ITEMS, 1'b0);
    configure('0, $urandom(), $urandom(), $urandom(), $urandom());
    sink_idle_on = 1'b0;
    run_phase(PHASE_ITEMS, 1'b1);

    settle_block();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_ready
    m_axis_tready <= 1'b0;
    forever begin
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    servo_out_t got, want;
    int a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(servo_out_t)-1:0];
      if (servo_out_q.size() == 0) begin
        note_mismatch("result with no request outstanding", got.vel[0], '0);
      end else begin
        want = servo_out_q.pop_front();
        for (a = 0; a < 3; a++) begin
          if (got.vel[a] !== want.vel[a])
            note_mismatch($sformatf("vel axis %0d", a), got.vel[a], want.vel[a]);
          if (got.tool_force[a] !== want.tool_force[a])
            note_mismatch($sformatf("force axis %0d", a), got.tool_force[a],
                          want.tool_force[a]);
        end
        if (got.btn_one !== want.btn_one)
          note_mismatch("button_one", 32'(got.btn_one), 32'(want.btn_one));
        if (got.btn_two !== want.btn_two)
          note_mismatch("button_two", 32'(got.btn_two), 32'(want.btn_two));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                 stall_cycles, servo_out_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
